// ----- src/websocket_frame_deframer_assert.svh -----
// Assertion macros for the WebSocket frame deframer.
// Used by the top level; expects a clock named i_clk and a reset named i_rst_n.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks the state that follows a reset cycle.
`define WSD_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: parse phase codes, header
// constants and the result word type. No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

    typedef enum logic [4:0] {
        PH_FIRST = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_EXT   = 5'b00100,
        PH_KEY   = 5'b01000,
        PH_PAY   = 5'b10000
    } t_phase;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Header bytes still due after the current one, minus one.
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [2:0] KEY_LEFT   = 3'd3;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_in_frame;
        logic       empty_frame;
    } t_result;

endpackage

// ----- src/wsd_stream_if.sv -----
// Valid/ready stream interfaces for the WebSocket frame deframer:
// the received byte channel and the result channel. No dependencies.
`timescale 1ns / 1ps

interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_in_frame;
    logic       empty_frame;

    modport source (output valid, output payload_byte, output last_in_frame,
                    output empty_frame, input ready);
    modport sink   (input valid, input payload_byte, input last_in_frame,
                    input empty_frame, output ready);
endinterface

// ----- src/wsd_parser.sv -----
// Frame header parser and payload unmasker: holds the parse state and
// produces at most one result word per accepted byte. Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic        r_mask,   n_mask;
    logic [63:0] r_len,    n_len;
    logic [2:0]  r_hbl,    n_hbl;
    logic [31:0] r_key,    n_key;
    logic [63:0] r_pbl,    n_pbl;
    logic [1:0]  r_kpos,   n_kpos;

    logic [6:0]  len7;
    logic [63:0] ext_len;
    logic [63:0] len_val;
    logic [63:0] start_len;
    logic        len_done;
    logic        start;
    logic        mask_eff;
    logic        last;
    logic [7:0]  key_byte;

    always_comb begin
        n_phase     = r_phase;
        n_mask      = r_mask;
        n_len       = r_len;
        n_hbl       = r_hbl;
        n_key       = r_key;
        n_pbl       = r_pbl;
        n_kpos      = r_kpos;
        o_res_valid = 1'b0;
        o_res       = '0;
        len7        = i_rx_byte[6:0];
        ext_len     = {r_len[55:0], i_rx_byte};
        len_val     = '0;
        start_len   = r_len;
        len_done    = 1'b0;
        start       = 1'b0;
        mask_eff    = r_mask;
        last        = (r_pbl[63:1] == 63'd0);
        case (r_kpos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase

        case (r_phase)
            PH_LEN: begin
                n_mask   = i_rx_byte[7];
                mask_eff = i_rx_byte[7];
                n_len    = '0;
                if (len7 == LEN_EXT16) begin
                    n_hbl   = EXT16_LEFT;
                    n_phase = PH_EXT;
                end else if (len7 == LEN_EXT64) begin
                    n_hbl   = EXT64_LEFT;
                    n_phase = PH_EXT;
                end else begin
                    len_done = 1'b1;
                    len_val  = {57'd0, len7};
                    n_len    = {57'd0, len7};
                end
            end
            PH_EXT: begin
                n_len = ext_len;
                if (r_hbl == 3'd0) begin
                    len_done = 1'b1;
                    len_val  = ext_len;
                end else begin
                    n_hbl = r_hbl - 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_rx_byte};
                if (r_hbl == 3'd0) begin
                    start     = 1'b1;
                    start_len = r_len;
                end else begin
                    n_hbl = r_hbl - 3'd1;
                end
            end
            PH_PAY: begin
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_rx_byte ^ key_byte;
                o_res.last_in_frame = last;
                o_res.empty_frame   = 1'b0;
                n_kpos              = r_kpos + 2'd1;
                if (last) begin
                    n_pbl   = '0;
                    n_kpos  = '0;
                    n_phase = PH_FIRST;
                end else begin
                    n_pbl = r_pbl - 64'd1;
                end
            end
            default: begin
                // FIN, RSV and opcode are not used.
                n_phase = PH_LEN;
            end
        endcase

        // Length complete: an unmasked frame goes straight to its payload
        // and keeps a zero key, so its bytes pass unchanged.
        if (len_done) begin
            n_key = '0;
            if (mask_eff) begin
                n_hbl   = KEY_LEFT;
                n_phase = PH_KEY;
            end else begin
                start     = 1'b1;
                start_len = len_val;
            end
        end

        if (start) begin
            n_kpos = '0;
            if (start_len == 64'd0) begin
                n_phase             = PH_FIRST;
                n_pbl               = '0;
                o_res_valid         = 1'b1;
                o_res.payload_byte  = '0;
                o_res.last_in_frame = 1'b1;
                o_res.empty_frame   = 1'b1;
            end else begin
                n_pbl   = start_len;
                n_phase = PH_PAY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_hbl   <= '0;
            r_key   <= '0;
            r_pbl   <= '0;
            r_kpos  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_hbl   <= n_hbl;
            r_key   <= n_key;
            r_pbl   <= n_pbl;
            r_kpos  <= n_kpos;
        end
    end

endmodule

// ----- src/websocket_frame_deframer.sv -----
// WebSocket frame deframer: parses back-to-back frames from a byte stream
// and returns unmasked payload bytes. Depends on wsd_pkg, the stream
// interfaces and wsd_parser. A result word is valid in the cycle after its
// byte is accepted. Throughput: one byte per cycle while results are taken,
// set by the single output register, refilled as it drains. Synchronous
// active-low reset returns the parser to the first header byte, no result.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wsd_byte_if.sink     i_rx,
    wsd_result_if.source o_res
);
    import wsd_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    // The output register is free when empty or being taken this cycle.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_accept  = i_rx.valid && i_rx.ready;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.last_in_frame = r_out.last_in_frame;
    assign o_res.empty_frame   = r_out.empty_frame;

    `WSD_ASSERT_IMP(a_empty_word, o_res.valid && o_res.empty_frame,
        o_res.last_in_frame && (o_res.payload_byte == 8'd0),
        "empty-frame word must be last and carry a zero byte")
    `WSD_ASSERT_NXT(a_result_loaded, in_accept && res_valid, o_res.valid,
        "result word of an accepted byte was not presented")
    `WSD_ASSERT_RST(a_reset_clear, !o_res.valid,
        "output word valid after reset")

endmodule

// ----- test/websocket_frame_deframer_tb.sv -----
// Testbench for websocket_frame_deframer: drives framed byte streams with random idling,
// predicts every result word in-bench and checks it field by field.
// Depends on wsd_pkg, the stream interfaces in wsd_stream_if.sv and the RTL top level.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

    import wsd_pkg::*;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_16BIT,
        LEN_64BIT
    } t_len_form;

    localparam int STALL_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsd_byte_if   rx_if ();
    wsd_result_if res_if ();

    websocket_frame_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Parser state as the predictor sees it.
    t_phase      cur_phase  = PH_FIRST;
    logic        mask_on    = 1'b0;
    logic [63:0] frame_len  = '0;
    logic [2:0]  hdr_left   = '0;
    logic [31:0] key_word   = '0;
    logic [63:0] bytes_left = '0;
    logic [1:0]  key_idx    = '0;

    t_result expected_words[$];

    bit gaps_on      = 1'b1;
    int mismatches   = 0;
    int frames_sent  = 0;
    int bytes_sent   = 0;
    int words_seen   = 0;
    int empties_seen = 0;
    int quiet_cycles = 0;

    // Appends one predicted word at the tail of the expected queue.
    task automatic expect_word(input t_result w);
        expected_words = {expected_words, w};
    endtask

    // Length and key are known: either start counting payload or flag an empty frame.
    task automatic open_payload();
        key_idx = '0;
        if (frame_len == 64'd0) begin
            cur_phase  = PH_FIRST;
            bytes_left = '0;
            expect_word('{payload_byte: 8'h00, last_in_frame: 1'b1, empty_frame: 1'b1});
        end else begin
            bytes_left = frame_len;
            cur_phase  = PH_PAY;
        end
    endtask

    task automatic close_length();
        key_word = '0;
        if (mask_on) begin
            hdr_left  = KEY_LEFT;
            cur_phase = PH_KEY;
        end else begin
            open_payload();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        t_result    word;
        logic [7:0] key_byte;
        case (cur_phase)
            PH_LEN: begin
                mask_on   = b[7];
                frame_len = '0;
                if (b[6:0] == LEN_EXT16) begin
                    hdr_left  = EXT16_LEFT;
                    cur_phase = PH_EXT;
                end else if (b[6:0] == LEN_EXT64) begin
                    hdr_left  = EXT64_LEFT;
                    cur_phase = PH_EXT;
                end else begin
                    frame_len = {57'd0, b[6:0]};
                    close_length();
                end
            end
            PH_EXT: begin
                frame_len = {frame_len[55:0], b};
                if (hdr_left == 3'd0) close_length();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_KEY: begin
                key_word = {key_word[23:0], b};
                if (hdr_left == 3'd0) open_payload();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_PAY: begin
                // Key bytes are applied most significant first, cycling every four bytes.
                key_byte           = key_word[8*(3 - key_idx) +: 8];
                word.payload_byte  = b ^ key_byte;
                word.last_in_frame = (bytes_left <= 64'd1);
                word.empty_frame   = 1'b0;
                expect_word(word);
                key_idx = key_idx + 2'd1;
                if (word.last_in_frame) begin
                    bytes_left = '0;
                    key_idx    = '0;
                    cur_phase  = PH_FIRST;
                end else begin
                    bytes_left = bytes_left - 64'd1;
                end
            end
            default: cur_phase = PH_LEN;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on) begin
            while ($urandom_range(99) < 23) begin
                rx_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    // Sends a header and pay_bytes payload words; pay_bytes equals len except for
    // frames too long to finish.
    task automatic send_frame(input logic [7:0] op_byte, input bit masked,
                              input t_len_form form, input logic [63:0] len,
                              input logic [31:0] key, input int pay_bytes);
        logic [6:0] len7;
        case (form)
            LEN_16BIT: len7 = LEN_EXT16;
            LEN_64BIT: len7 = LEN_EXT64;
            default:   len7 = len[6:0];
        endcase
        frames_sent++;
        send_byte(op_byte);
        send_byte({masked, len7});
        if (form == LEN_16BIT) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else if (form == LEN_64BIT) begin
            for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
        end
        for (int i = 0; i < pay_bytes; i++) send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_short_frames();
        send_frame(8'h81, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
        send_frame(8'h00, 1'b0, LEN_SHORT, 64'd1, 32'h0, 1);
        send_frame(8'hFF, 1'b1, LEN_SHORT, 64'd3, 32'hFFFF_FFFF, 3);
        // A masked empty frame flags on the last key byte.
        send_frame(8'h89, 1'b1, LEN_SHORT, 64'd0, 32'h0000_0000, 0);
    endtask

    task automatic test_extended_lengths();
        send_frame(8'h82, 1'b0, LEN_16BIT, 64'd0, 32'h0, 0);
        send_frame(8'h02, 1'b1, LEN_16BIT, 64'd2, 32'h0000_00FF, 2);
        send_frame(8'h88, 1'b0, LEN_64BIT, 64'd0, 32'h0, 0);
        send_frame(8'h0A, 1'b1, LEN_64BIT, 64'd1, 32'hA5C3_0F81, 1);
    endtask

    task automatic test_key_rotation();
        send_frame(8'h81, 1'b1, LEN_SHORT, 64'd9, 32'h0123_4567, 9);
    endtask

    task automatic test_random_frames(input int byte_target);
        int          sel;
        t_len_form   form;
        logic [63:0] len;
        while (bytes_sent < byte_target) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                form = LEN_SHORT;
                len  = 64'($urandom_range(12));
            end else if (sel < 72) begin
                form = LEN_SHORT;
                len  = 64'($urandom_range(125));
            end else if (sel < 88) begin
                form = LEN_16BIT;
                len  = ($urandom_range(9) == 0) ? 64'($urandom_range(300, 126))
                                                : 64'($urandom_range(40));
            end else begin
                form = LEN_64BIT;
                len  = 64'($urandom_range(24));
            end
            send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), form, len,
                       $urandom(), int'(len));
        end
    endtask

    task automatic test_back_to_back(input int byte_target);
        gaps_on = 1'b0;
        test_random_frames(byte_target);
        gaps_on = 1'b1;
    endtask

    // Length with the top bit set: the frame never ends, so this runs last.
    task automatic test_huge_length();
        send_frame(8'h82, 1'b1, LEN_64BIT, 64'hFFFF_FFFF_FFFF_FFFF, $urandom(), 16);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with none expected: payload_byte %02h", res_if.payload_byte);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                words_seen++;
                if (want.empty_frame) empties_seen++;
                if (res_if.payload_byte !== want.payload_byte) begin
                    $error("payload_byte expected %02h actual %02h",
                           want.payload_byte, res_if.payload_byte);
                    mismatches++;
                end
                if (res_if.last_in_frame !== want.last_in_frame) begin
                    $error("last_in_frame expected %0b actual %0b",
                           want.last_in_frame, res_if.last_in_frame);
                    mismatches++;
                end
                if (res_if.empty_frame !== want.empty_frame) begin
                    $error("empty_frame expected %0b actual %0b",
                           want.empty_frame, res_if.empty_frame);
                    mismatches++;
                end
            end
        end
        res_if.ready <= !gaps_on || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL websocket_frame_deframer");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_frames();
        test_extended_lengths();
        test_key_rotation();
        test_random_frames(450);
        test_back_to_back(600);
        test_huge_length();

        rx_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d frames (%0d bytes) of every length form, masked and unmasked.",
                 frames_sent, bytes_sent);
        $display("Checked %0d result words, %0d of them empty-frame markers.",
                 words_seen, empties_seen);
        if (mismatches == 0)
            $display("PASS websocket_frame_deframer");
        else
            $display("FAIL websocket_frame_deframer");
        $finish;
    end

endmodule
